// ----- rtl/eio_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eio_pkg
// Shared constants and codes of the ease-in/out phase core.
// ----------------------------------------------------------------------------
package eio_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF = 32;

  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [29:0] K_2PI = 30'd683565276;
  localparam logic [30:0] S_A   = 31'd1686629713;
  localparam logic [29:0] S_B   = 30'd688904866;
  localparam logic [26:0] S_C   = 27'd76016977;

  localparam int unsigned CFG_SETTLE = 6;

  typedef enum logic [2:0] {
    MODE_LINEAR   = 3'd0,
    MODE_PAR_FRAC = 3'd1,
    MODE_SIN_FRAC = 3'd2,
    MODE_PAR_TIME = 3'd3,
    MODE_SIN_TIME = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_EIN_FRAC  = 3'd1,
    REG_EOUT_FRAC = 3'd2,
    REG_EIN_TIME  = 3'd3,
    REG_PERIOD    = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_LINEAR,
    CLS_PARAB,
    CLS_SINE
  } cls_e;

  typedef enum logic [1:0] {
    RG_EASE_IN,
    RG_CRUISE,
    RG_EASE_OUT
  } rg_e;

endpackage
`default_nettype wire

// ----- rtl/eio_time_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eio_time_if
// Input channel: one signed time value per item.
// ----------------------------------------------------------------------------
interface eio_time_if import eio_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [TIME_BITS-1:0] time_now;

  modport source (output valid, output time_now, input ready);
  modport sink   (input valid, input time_now, output ready);
endinterface
`default_nettype wire

// ----- rtl/eio_phase_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eio_phase_if
// Output channel: one phase value per item.
// ----------------------------------------------------------------------------
interface eio_phase_if import eio_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) ();
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] phase;

  modport source (output valid, output phase, input ready);
  modport sink   (input valid, input phase, output ready);
endinterface
`default_nettype wire

// ----- rtl/ease_in_out_phase_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ease_in_out_phase_core
// Maps elapsed time to a Q1.FRAC_BITS motion phase: linear, parabolic or
// sinusoidal ease-in/out over a configured period.
// ----------------------------------------------------------------------------
// channel  dir  handshake     payload
// in_if    in   valid/ready   time_now  (TIME_BITS, signed)
// out_if   out  valid/ready   phase     (FRAC_BITS+1, unsigned)
// cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// One item per cycle unless the skid register is full or the period terms
// settle; items pass the 31-stage angle divider, the sine stages and the
// FRAC_BITS+1-stage phase divider. After reset and after each register
// write, in_if.ready stays low while the derived period terms settle.
// A stalled output holds one item plus one in a skid register, then the
// whole pipeline holds.
// ----------------------------------------------------------------------------
module ease_in_out_phase_core import eio_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF,
  localparam int unsigned TW = TIME_BITS - 1,
  localparam int unsigned FW = FRAC_BITS + 1,
  localparam int unsigned CW = (TW > FW) ? TW : FW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [CW-1:0] cfg_data_i,
  eio_time_if.sink      in_if,
  eio_phase_if.source   out_if
);

  localparam int unsigned WW = (2 * TW + 2 > TW + 31) ? 2 * TW + 2 : TW + 31;
  localparam int unsigned AW = TW + 1;
  localparam int unsigned PW = 2 * TW + 1;
  localparam int unsigned SCW = $clog2(CFG_SETTLE + 1);
  localparam logic [FW-1:0] FULL = FW'(1) << FRAC_BITS;

  typedef struct packed {
    logic          sp;
    logic [FW-1:0] spv;
    rg_e           rg;
    logic [TW-1:0] t;
  } tag_t;

  localparam int unsigned SW = $bits(tag_t);

  // configuration
  logic [2:0]     mode_q;
  logic [FW-1:0]  ein_q, eout_q;
  logic [TW-1:0]  etime_q, per_q;
  logic [SCW-1:0] settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LINEAR;
      ein_q   <= '0;
      eout_q  <= FULL;
      etime_q <= '0;
      per_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:      mode_q  <= cfg_data_i[2:0];
        REG_EIN_FRAC:  ein_q   <= cfg_data_i[FW-1:0];
        REG_EOUT_FRAC: eout_q  <= cfg_data_i[FW-1:0];
        REG_EIN_TIME:  etime_q <= cfg_data_i[TW-1:0];
        REG_PERIOD:    per_q   <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SCW'(CFG_SETTLE);
    end else if (cfg_we_i) begin
      settle_q <= SCW'(CFG_SETTLE);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - SCW'(1);
    end
  end

  cls_e cls;
  logic frac;

  always_comb begin
    frac = mode_q inside {MODE_PAR_FRAC, MODE_SIN_FRAC};
    if (mode_q inside {MODE_PAR_FRAC, MODE_PAR_TIME}) begin
      cls = CLS_PARAB;
    end else if (mode_q inside {MODE_SIN_FRAC, MODE_SIN_TIME}) begin
      cls = CLS_SINE;
    end else begin
      cls = CLS_LINEAR;
    end
  end

  // derived period terms
  logic [FW+TW-1:0] pin, pout;
  logic [TW:0]      t1r_q, t2r_q;
  logic [TW-1:0]    t1c, t2c;
  logic [TW:0]      tsum;
  logic [TW-1:0]    t1_q, t2_q, tm_q, gap_q;
  logic [TW:0]      d_q;
  logic [TW+29:0]   t1k_q, tmk_q;
  logic [PW-1:0]    t1d_q, tmd_q;
  logic [WW-1:0]    base_q, q_q;

  assign pin  = (FW+TW)'(ein_q) * (FW+TW)'(per_q);
  assign pout = (FW+TW)'(eout_q) * (FW+TW)'(per_q);

  always_comb begin
    t1c  = (t1r_q > {1'b0, per_q}) ? per_q : t1r_q[TW-1:0];
    t2c  = (t2r_q > {1'b0, per_q}) ? per_q : t2r_q[TW-1:0];
    tsum = {1'b0, t1c} + {1'b0, t2c};
  end

  always_ff @(posedge clk_i) begin
    t1r_q <= frac ? pin[FRAC_BITS +: TW+1] : {1'b0, etime_q};
    if (frac) begin
      t2r_q <= pout[FRAC_BITS +: TW+1];
    end else begin
      t2r_q <= (per_q >= etime_q) ? {1'b0, per_q - etime_q} : '0;
    end
    t1_q   <= (t1c > t2c) ? tsum[TW:1] : t1c;
    t2_q   <= (t1c > t2c) ? tsum[TW:1] : t2c;
    d_q    <= {1'b0, t2_q} - {1'b0, t1_q} + {1'b0, per_q};
    tm_q   <= per_q - t2_q;
    gap_q  <= t2_q - t1_q;
    t1k_q  <= (TW+30)'(t1_q) * (TW+30)'(K_2PI);
    tmk_q  <= (TW+30)'(tm_q) * (TW+30)'(K_2PI);
    t1d_q  <= PW'(t1_q) * PW'(d_q);
    tmd_q  <= PW'(tm_q) * PW'(d_q);
    base_q <= WW'(t1k_q) + (WW'(gap_q) << 30);
    q_q    <= base_q + WW'(tmk_q);
  end

  // input and output control
  logic             adv, in_fire;
  logic             out_v_q, skid_v_q;
  logic [FW-1:0]    out_q, skid_q;
  logic             pd_v;
  logic [FW-1:0]    pd_quo;
  logic [FW:0]      pd_side;
  logic [FW-1:0]    res;
  logic             pop, push;

  assign adv         = !skid_v_q;
  assign in_if.ready = adv && (settle_q == '0);
  assign in_fire     = in_if.valid && in_if.ready;

  // accept stage
  logic                 a_v_q;
  logic [TIME_BITS-1:0] a_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_t_q <= in_if.time_now;
    end
  end

  // classify stage
  logic [TW-1:0] tt;
  tag_t          b_tag_d;
  logic [AW-1:0] b_num_d, b_den_d;
  logic          b_v_q;
  tag_t          b_tag_q;
  logic [AW-1:0] b_num_q, b_den_q;

  assign tt = a_t_q[TW-1:0];

  always_comb begin
    b_tag_d.t = tt;
    if (per_q == '0) begin
      b_tag_d.sp  = 1'b1;
      b_tag_d.spv = FULL;
    end else if (a_t_q[TIME_BITS-1]) begin
      b_tag_d.sp  = 1'b1;
      b_tag_d.spv = '0;
    end else if (tt >= per_q) begin
      b_tag_d.sp  = 1'b1;
      b_tag_d.spv = FULL;
    end else begin
      b_tag_d.sp  = 1'b0;
      b_tag_d.spv = '0;
    end
    if (tt < t1_q) begin
      b_tag_d.rg = RG_EASE_IN;
    end else if ((cls == CLS_PARAB) ? (tt <= t2_q) : (tt < t2_q)) begin
      b_tag_d.rg = RG_CRUISE;
    end else begin
      b_tag_d.rg = RG_EASE_OUT;
    end
    if (b_tag_d.rg == RG_EASE_IN) begin
      b_num_d = {1'b0, tt};
      b_den_d = {1'b0, t1_q};
    end else begin
      b_num_d = {1'b0, tt - t2_q};
      b_den_d = {1'b0, tm_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (adv) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_tag_q <= b_tag_d;
      b_num_q <= b_num_d;
      b_den_q <= b_den_d;
    end
  end

  // quarter-turn position
  logic          ad_v;
  logic [30:0]   ad_quo;
  logic [SW-1:0] ad_side;
  tag_t          ad_tag;
  logic [30:0]   sq_u;

  eio_div #(.RW(AW), .QB(31), .SW(SW)) u_angle_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (b_v_q),
    .num_i   (b_num_q),
    .den_i   (b_den_q),
    .side_i  (b_tag_q),
    .valid_o (ad_v),
    .quo_o   (ad_quo),
    .side_o  (ad_side)
  );

  assign ad_tag = tag_t'(ad_side);
  assign sq_u   = (ad_tag.rg == RG_EASE_IN) ? ONE30 - ad_quo : ad_quo;

  logic          sq_v;
  logic [30:0]   sq_s;
  logic [SW-1:0] sq_side;
  tag_t          sq_tag;

  eio_sinq #(.SW(SW)) u_sinq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (ad_v),
    .u_i     (sq_u),
    .side_i  (ad_side),
    .valid_o (sq_v),
    .s_o     (sq_s),
    .side_o  (sq_side)
  );

  assign sq_tag = tag_t'(sq_side);

  // ramp scale and parabolic products
  logic [30:0]   cc;
  logic [60:0]   pw;
  logic [TW:0]   e_twot;
  logic [TW-1:0] e_dt;
  logic          e_v_q;
  tag_t          e_tag_q;
  logic [29:0]   e_w_q;
  logic [PW-1:0] e_pa_q, e_pb_q;

  always_comb begin
    cc     = (sq_tag.rg == RG_EASE_IN) ? ONE30 - sq_s : sq_s;
    pw     = 61'(K_2PI) * 61'(cc);
    e_twot = {sq_tag.t, 1'b0} - {1'b0, t1_q};
    e_dt   = sq_tag.t - t2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (adv) begin
      e_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_tag_q <= sq_tag;
      e_w_q   <= pw[59:30];
      if (sq_tag.rg == RG_EASE_IN) begin
        e_pa_q <= PW'(sq_tag.t) * PW'(sq_tag.t);
      end else begin
        e_pa_q <= PW'(e_twot) * PW'(tm_q);
      end
      e_pb_q <= PW'(e_dt) * PW'(e_dt);
    end
  end

  // sine ramp area
  logic           f_v_q;
  tag_t           f_tag_q;
  logic [TW+29:0] f_sm_q;
  logic [PW-1:0]  f_pa_q, f_pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (adv) begin
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_tag_q <= e_tag_q;
      f_sm_q  <= (TW+30)'((e_tag_q.rg == RG_EASE_IN) ? t1_q : tm_q) * (TW+30)'(e_w_q);
      f_pa_q  <= e_pa_q;
      f_pb_q  <= e_pb_q;
    end
  end

  // dividend and divisor select
  logic [TW:0]   g_twot;
  logic [WW-1:0] g_num_d, g_den_d;
  logic          g_v_q;
  tag_t          g_tag_q;
  logic [WW-1:0] g_num_q, g_den_q;

  always_comb begin
    g_twot = {f_tag_q.t, 1'b0} - {1'b0, t1_q};
    case (cls)
      CLS_PARAB: begin
        case (f_tag_q.rg)
          RG_EASE_IN: begin
            g_num_d = WW'(f_pa_q);
            g_den_d = WW'(t1d_q);
          end
          RG_CRUISE: begin
            g_num_d = WW'(g_twot);
            g_den_d = WW'(d_q);
          end
          default: begin
            g_num_d = (f_pa_q >= f_pb_q) ? WW'(f_pa_q - f_pb_q) : '0;
            g_den_d = WW'(tmd_q);
          end
        endcase
      end
      CLS_SINE: begin
        case (f_tag_q.rg)
          RG_EASE_IN: g_num_d = WW'(f_sm_q);
          RG_CRUISE:  g_num_d = WW'(t1k_q) + (WW'(f_tag_q.t - t1_q) << 30);
          default:    g_num_d = base_q + WW'(f_sm_q);
        endcase
        g_den_d = q_q;
      end
      default: begin
        g_num_d = WW'(f_tag_q.t);
        g_den_d = WW'(per_q);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
    end else if (adv) begin
      g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_tag_q <= f_tag_q;
      g_num_q <= g_num_d;
      g_den_q <= g_den_d;
    end
  end

  // phase division
  eio_div #(.RW(WW), .QB(FW), .SW(FW + 1)) u_phase_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (g_v_q),
    .num_i   (g_num_q),
    .den_i   (g_den_q),
    .side_i  ({g_tag_q.sp, g_tag_q.spv}),
    .valid_o (pd_v),
    .quo_o   (pd_quo),
    .side_o  (pd_side)
  );

  assign res  = pd_side[FW] ? pd_side[FW-1:0] : ((pd_quo > FULL) ? FULL : pd_quo);
  assign pop  = out_v_q && out_if.ready;
  assign push = adv && pd_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      out_q <= skid_v_q ? skid_q : res;
    end
    if (out_v_q && !pop && push) begin
      skid_q <= res;
    end
  end

  assign out_if.valid = out_v_q;
  assign out_if.phase = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_we_i |=> !in_if.ready)
    else $error("item accepted right after a register write");
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> out_v_q)
    else $error("skid holds an item while the output is empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_v_q |-> (out_q <= FULL))
    else $error("phase above full scale");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (a_v_q && adv) |=> b_v_q)
    else $error("item lost between accept and classify stages");

endmodule
`default_nettype wire

// ----- rtl/eio_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eio_div
// Pipelined restoring divider, one quotient bit per stage, with side tag.
// ----------------------------------------------------------------------------
module eio_div #(
  parameter int unsigned RW = 64,
  parameter int unsigned QB = 17,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [RW-1:0] num_i,
  input  logic [RW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QB-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [QB-1:0] v_q;
  logic [RW-1:0] r_q  [QB];
  logic [RW-1:0] d_q  [QB];
  logic [QB-1:0] qt_q [QB];
  logic [SW-1:0] s_q  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0] r_in, d_in, r_d;
    logic [QB-1:0] qt_in, qt_d;
    logic [SW-1:0] s_in;
    logic          v_in;

    if (k == 0) begin : g_first
      assign r_in  = num_i;
      assign d_in  = den_i;
      assign qt_in = '0;
      assign s_in  = side_i;
      assign v_in  = valid_i;
    end else begin : g_next
      assign r_in  = {r_q[k-1][RW-2:0], 1'b0};
      assign d_in  = d_q[k-1];
      assign qt_in = qt_q[k-1];
      assign s_in  = s_q[k-1];
      assign v_in  = v_q[k-1];
    end

    always_comb begin
      if (r_in >= d_in) begin
        r_d  = r_in - d_in;
        qt_d = {qt_in[QB-2:0], 1'b1};
      end else begin
        r_d  = r_in;
        qt_d = {qt_in[QB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= r_d;
        d_q[k]  <= d_in;
        qt_q[k] <= qt_d;
        s_q[k]  <= s_in;
      end
    end
  end

  assign valid_o = v_q[QB-1];
  assign quo_o   = qt_q[QB-1];
  assign side_o  = s_q[QB-1];

endmodule
`default_nettype wire

// ----- rtl/eio_sinq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eio_sinq
// Four-stage quarter-sine polynomial in Q30, one product per stage.
// ----------------------------------------------------------------------------
module eio_sinq import eio_pkg::*; #(
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [30:0]   u_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [30:0]   s_o,
  output logic [SW-1:0] side_o
);

  logic [3:0]    v_q;
  logic [SW-1:0] s_q [4];
  logic [30:0]   u1_q, u2_q, u3_q;
  logic [30:0]   z1_q, z2_q;
  logic [29:0]   inner_q;
  logic [30:0]   mid_q;
  logic [30:0]   res_q;

  logic [61:0] p1, p4;
  logic [57:0] p2;
  logic [60:0] p3;
  logic [31:0] r4;

  assign p1 = 62'(u_i) * 62'(u_i);
  assign p2 = 58'(z1_q) * 58'(S_C);
  assign p3 = 61'(z2_q) * 61'(inner_q);
  assign p4 = 62'(u3_q) * 62'(mid_q);
  assign r4 = p4[61:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0]  <= side_i;
      s_q[1]  <= s_q[0];
      s_q[2]  <= s_q[1];
      s_q[3]  <= s_q[2];
      u1_q    <= u_i;
      z1_q    <= p1[60:30];
      u2_q    <= u1_q;
      z2_q    <= z1_q;
      inner_q <= S_B - {2'b00, p2[57:30]};
      u3_q    <= u2_q;
      mid_q   <= S_A - p3[60:30];
      res_q   <= (r4 > 32'(ONE30)) ? ONE30 : r4[30:0];
    end
  end

  assign valid_o = v_q[3];
  assign s_o     = res_q;
  assign side_o  = s_q[3];

endmodule
`default_nettype wire

// ----- verif/eio_phase_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eio_phase_checker
// Watches the configuration port and both channels of the ease-in/out phase
// core. It keeps a shadow of the registers, computes the expected phase of
// every accepted time item, and compares each delivered phase in order.
// ----------------------------------------------------------------------------
module eio_phase_checker import eio_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  eio_time_if         tin,
  eio_phase_if        pout,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);

  typedef logic [127:0] w_t;

  localparam w_t FULL = w_t'(1) << 16;

  logic [2:0]  mode_q;
  logic [16:0] ein_frac_q;
  logic [16:0] eout_frac_q;
  logic [30:0] ein_time_q;
  logic [30:0] period_q;
  logic [16:0] phase_q[$];

  function automatic w_t quarter_sine(w_t x);
    w_t xs, z2, inner, mid, r;
    xs = (x > w_t'(ONE30)) ? w_t'(ONE30) : x;
    z2 = (xs * xs) >> 30;
    inner = w_t'(S_B) - ((z2 * w_t'(S_C)) >> 30);
    mid = w_t'(S_A) - ((z2 * inner) >> 30);
    r = (xs * mid) >> 30;
    return (r > w_t'(ONE30)) ? w_t'(ONE30) : r;
  endfunction

  function automatic w_t fdiv(w_t n, w_t d);
    return (d == 0) ? w_t'(0) : n / d;
  endfunction

  function automatic logic [16:0] expected_phase(logic [31:0] raw);
    w_t tt, tp, t1, t2, dd, ph, a, b, num, base, q, s, x, c, y, kk, one;
    tp = w_t'(period_q);
    kk = w_t'(K_2PI);
    one = w_t'(ONE30);
    if (tp == 0) return 17'(FULL);
    if (raw[31]) return '0;
    tt = w_t'(raw);
    if (tt >= tp) return 17'(FULL);
    if (mode_q == MODE_PAR_FRAC || mode_q == MODE_SIN_FRAC) begin
      t1 = (w_t'(ein_frac_q) * tp) >> 16;
      t2 = (w_t'(eout_frac_q) * tp) >> 16;
    end else begin
      t1 = w_t'(ein_time_q);
      t2 = (tp >= t1) ? tp - t1 : w_t'(0);
    end
    if (t1 > tp) t1 = tp;
    if (t2 > tp) t2 = tp;
    if (t1 > t2) begin
      t1 = (t1 + t2) >> 1;
      t2 = t1;
    end
    if (mode_q == MODE_PAR_FRAC || mode_q == MODE_PAR_TIME) begin
      dd = t2 - t1 + tp;
      if (tt < t1) begin
        ph = fdiv((tt * tt) << 16, t1 * dd);
      end else if (tt <= t2) begin
        ph = fdiv((2 * tt - t1) << 16, dd);
      end else begin
        a = (2 * tt - t1) * (tp - t2);
        b = (tt - t2) * (tt - t2);
        num = (a >= b) ? a - b : w_t'(0);
        ph = fdiv(num << 16, (tp - t2) * dd);
      end
    end else if (mode_q == MODE_SIN_FRAC || mode_q == MODE_SIN_TIME) begin
      base = t1 * kk + ((t2 - t1) << 30);
      q = base + (tp - t2) * kk;
      if (tt < t1) begin
        x = fdiv(tt << 30, t1);
        c = quarter_sine(one - ((x > one) ? one : x));
        s = t1 * ((kk * (one - c)) >> 30);
      end else if (tt < t2) begin
        s = t1 * kk + ((tt - t1) << 30);
      end else begin
        y = fdiv((tt - t2) << 30, tp - t2);
        s = base + (tp - t2) * ((kk * quarter_sine(y)) >> 30);
      end
      ph = fdiv(s << 16, q);
    end else begin
      ph = fdiv(tt << 16, tp);
    end
    if (ph > FULL) ph = FULL;
    return 17'(ph);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [16:0] exp_ph;
    if (!rst_ni) begin
      mode_q      = MODE_LINEAR;
      ein_frac_q  = '0;
      eout_frac_q = 17'(FULL);
      ein_time_q  = '0;
      period_q    = '0;
      phase_q.delete();
      errors_o    = 0;
      checked_o   = 0;
      pending_o   = 0;
    end else begin
      if (tin.valid && tin.ready) phase_q.insert(phase_q.size(), expected_phase(tin.time_now));
      if (pout.valid && pout.ready) begin
        if (phase_q.size() == 0) begin
          $display("%0t: phase %0d delivered with none expected", $time, pout.phase);
          errors_o++;
        end else begin
          exp_ph = phase_q.pop_front();
          checked_o++;
          if (pout.phase !== exp_ph) begin
            $display("%0t: phase mismatch, expected %0d, actual %0d",
                     $time, exp_ph, pout.phase);
            errors_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:      mode_q = cfg_data_i[2:0];
          REG_EIN_FRAC:  ein_frac_q = cfg_data_i[16:0];
          REG_EOUT_FRAC: eout_frac_q = cfg_data_i[16:0];
          REG_EIN_TIME:  ein_time_q = cfg_data_i;
          REG_PERIOD:    period_q = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = phase_q.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the phase core testbench: drives directed and random time items
// over many register settings with random idling on both channels, a long
// output hold-off and drained pauses; the checker judges every phase.
// ----------------------------------------------------------------------------
module tb;
  import eio_pkg::*;

  localparam int unsigned LATENCY = 41 + FRAC_BITS_DEF + 4;
  localparam int unsigned LIMIT = 400000;
  localparam int unsigned PHASES = 14;
  localparam int unsigned ITEMS_PER_PHASE = 64;
  localparam logic [30:0] TMAX = 31'h7FFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = REG_MODE;
  logic [30:0] cfg_data_i = '0;
  int          err_cnt, pending, checked;
  int          sent = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  logic [30:0] cur_period;

  eio_time_if  in_if ();
  eio_phase_if out_if ();

  initial begin
    in_if.valid = 1'b0;
    in_if.time_now = '0;
    out_if.ready = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  ease_in_out_phase_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  eio_phase_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .tin(in_if), .pout(out_if),
    .errors_o(err_cnt), .pending_o(pending), .checked_o(checked)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : phase_sink
    int  stall;
    logic seen;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        seen = out_if.valid;
        if (!seen) @(posedge clk_i);
      end while (!seen);
    end
  end

  task automatic send_time(logic [31:0] t);
    int   gap;
    logic seen;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.time_now <= t;
    do begin
      @(negedge clk_i);
      seen = in_if.ready;
      @(posedge clk_i);
    end while (!seen);
    sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [30:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == REG_PERIOD) cur_period = data;
  endtask

  task automatic configure(logic [2:0] mode, logic [16:0] fin, logic [16:0] fout,
                           logic [30:0] etime, logic [30:0] per);
    write_reg(REG_MODE, 31'(mode));
    write_reg(REG_EIN_FRAC, 31'(fin));
    write_reg(REG_EOUT_FRAC, 31'(fout));
    write_reg(REG_EIN_TIME, etime);
    write_reg(REG_PERIOD, per);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_time(logic [30:0] per);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (per == 0 || sel == 9) return $urandom;
    if (sel <= 6) return 32'($urandom_range(0, per - 1));
    if (sel == 7) return 32'(per) + $urandom_range(0, 3);
    return -32'($urandom_range(1, 1000));
  endfunction

  function automatic logic [30:0] rand_period();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(1, 3));
      1: return 31'($urandom_range(1, 64));
      2: return 31'($urandom_range(1, 100000));
      3: return 31'($urandom);
      4: return TMAX;
      default: return 31'($urandom_range(100, 5000));
    endcase
  endfunction

  function automatic logic [16:0] rand_frac();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 17'h10000;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin : stimulus
    logic [30:0] per;
    logic [2:0]  mode;
    logic [16:0] fin, fout;
    logic [30:0] etime;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_time(32'h8000_0000);
    send_time(32'h0000_0000);
    send_time(32'h7FFF_FFFF);
    drain();
    for (int m = MODE_LINEAR; m <= MODE_SIN_TIME; m++) begin
      configure(3'(m), 17'd16384, 17'd49152, 31'd250, 31'd1000);
      send_time(32'd0);
      send_time(32'd125);
      send_time(32'd500);
      send_time(32'd875);
      drain();
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) configure(MODE_SIN_TIME, 17'h1FFFF, 17'h1FFFF, TMAX, TMAX);
      else if (p == 1) configure(MODE_PAR_FRAC, '0, '0, '0, 31'd1);
      else if (p == 2) configure(3'(MODE_SIN_TIME) + 3'd3, 17'd100, 17'd200, 31'd7, 31'd999);
      else if (p == 3) configure(MODE_PAR_FRAC, 17'd50000, 17'd10000, '0, 31'd4096);
      else begin
        per = rand_period();
        mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
        fin = rand_frac();
        fout = rand_frac();
        case ($urandom_range(0, 3))
          0: etime = '0;
          1: etime = TMAX;
          2: etime = 31'($urandom);
          default: etime = 31'($urandom_range(0, per));
        endcase
        configure(mode, fin, fout, etime, per);
      end
      quiet = (p % 4 == 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 5 && i == 8) hold_req = 1'b1;
        send_time(rand_time(cur_period));
      end
      drain();
    end

    quiet = 1'b0;
    drain();
    $display("covered %0d time items over %0d register settings, %0d phases checked",
             sent, PHASES + 6, checked);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (pending != 0) $display("%0d expected phases never delivered", pending);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
